[rtl/core/mmd_pkg.sv]
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants of the dense matrix multiply block: field widths,
// command and register codes, and the beat that runs along the cell chain.
// ----------------------------------------------------------------------------
package mmd_pkg;

    // default largest matrix side
    localparam int MAX_DIM_DEF = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 36;
    localparam int SIZE_W  = 4;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    // one A element moving down the chain with its inner index
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic [IDX_W-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } t_lane;

    // broadcast write of one B element
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] data;
    } t_bwr;

endpackage

[rtl/core/mmd_cell.sv]
// ----------------------------------------------------------------------------
// mmd_cell
// One multiply-accumulate cell of the chain. Holds one column of B and the
// running sum of one result column; passes the A beat to its right neighbor.
// ----------------------------------------------------------------------------
module mmd_cell #(
    parameter int MAX_DIM = mmd_pkg::MAX_DIM_DEF,
    parameter int COL_ID  = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmd_pkg::t_lane                  i_lane,
    input  mmd_pkg::t_bwr                   i_bwr,
    output mmd_pkg::t_lane                  o_lane,
    output logic signed [mmd_pkg::ACC_W-1:0] o_result
);

    localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [mmd_pkg::ELEM_W-1:0]         r_b [MAX_DIM];
    mmd_pkg::t_lane                     r_lane;
    logic signed [mmd_pkg::PROD_W-1:0]  r_prod;
    logic                               r_pvalid;
    logic                               r_pfirst;
    logic signed [mmd_pkg::ACC_W-1:0]   r_acc;
    logic signed [mmd_pkg::ACC_W-1:0]   n_acc;
    logic signed [mmd_pkg::ACC_W-1:0]   prod_ext;

    // column store of B, written by broadcast
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && (i_bwr.col == mmd_pkg::IDX_W'(COL_ID))) begin
            r_b[i_bwr.row[KW-1:0]] <= i_bwr.data;
        end
    end

    // pass the beat on to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_lane.valid;
        end
        r_lane.first <= i_lane.first;
        r_lane.k     <= i_lane.k;
        r_lane.a     <= i_lane.a;
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_lane.valid;
        end
        r_pfirst <= i_lane.first;
        r_prod   <= i_lane.a * $signed(r_b[i_lane.k[KW-1:0]]);
    end

    // accumulate stage, restarted by the first inner term
    assign prod_ext = {{(mmd_pkg::ACC_W - mmd_pkg::PROD_W){r_prod[mmd_pkg::PROD_W-1]}}, r_prod};

    always_comb begin
        n_acc = r_acc;
        if (r_pvalid) begin
            n_acc = r_pfirst ? prod_ext : (r_acc + prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_lane   = r_lane;
    assign o_result = r_acc;

endmodule

[rtl/core/matrix_multiply_dense.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_dense
// Dense product C = A x B on signed Q4.12 elements with Q12.24 sums. A sits
// in a local memory, B is spread over a chain of MAC cells, one per column.
//
//   channel   dir  signals                         beat carries
//   s         in   i_s_tvalid/o_s_tready/i_s_tdata  load A, load B or start
//   m         out  o_m_tvalid/i_m_tready/o_m_tdata  one C element, tlast at end
//                  o_m_tlast
//   cfg       in   i_cfg_we/i_cfg_index/i_cfg_data  rows_m, cols_n, inner_k
//
// A start beat runs row by row: row i of A streams into the cell chain,
// the chain drains, then the row of C is emitted; the chain length sets the
// drain. Reset is synchronous and clears control only; stores hold garbage
// until loaded. A stalled m side holds the emit loop; s is taken only when
// idle.
// ----------------------------------------------------------------------------
module matrix_multiply_dense #(
    parameter int MAX_DIM = mmd_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cmd[1:0], row_index[4:2], col_index[7:5], elem_value[23:8]
    input  logic [mmd_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // out_row[2:0], out_col[5:3], out_value[41:6], zero pad [47:42]
    output logic [mmd_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_we,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // input fields
    logic [mmd_pkg::CMD_W-1:0]  in_cmd;
    logic [mmd_pkg::IDX_W-1:0]  in_row;
    logic [mmd_pkg::IDX_W-1:0]  in_col;
    logic [mmd_pkg::ELEM_W-1:0] in_val;
    logic                       s_beat;
    logic                       in_range;

    assign in_cmd = i_s_tdata[1:0];
    assign in_row = i_s_tdata[4:2];
    assign in_col = i_s_tdata[7:5];
    assign in_val = i_s_tdata[23:8];

    assign s_beat   = i_s_tvalid && o_s_tready;
    assign in_range = ({1'b0, in_row} < 4'(MAX_DIM)) && ({1'b0, in_col} < 4'(MAX_DIM));

    // size registers, clamped on write
    logic [DW-1:0] r_rows, r_cols, r_inner;
    logic [DW-1:0] cfg_clamped;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = DW'(1);
        end else if (i_cfg_data > mmd_pkg::CFG_DATA_W'(MAX_DIM)) begin
            cfg_clamped = DW'(MAX_DIM);
        end else begin
            cfg_clamped = DW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DW'(MAX_DIM);
            r_cols  <= DW'(MAX_DIM);
            r_inner <= DW'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmd_pkg::REG_ROWS:  r_rows  <= cfg_clamped;
                mmd_pkg::REG_COLS:  r_cols  <= cfg_clamped;
                mmd_pkg::REG_INNER: r_inner <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [1:0]    r_state, n_state;
    logic [KW-1:0] r_i, n_i;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_j, n_j;
    logic [DW-1:0] r_drain, n_drain;
    logic          out_free;
    logic          emit;
    logic          last_k, last_j, last_i;

    assign out_free = !o_m_tvalid || i_m_tready;
    assign emit     = (r_state == ST_EMIT) && out_free;
    assign last_k   = (r_k == KW'(r_inner - DW'(1)));
    assign last_j   = (r_j == KW'(r_cols - DW'(1)));
    assign last_i   = (r_i == KW'(r_rows - DW'(1)));

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_j     = r_j;
        n_drain = r_drain;
        case (r_state)
            ST_IDLE: begin
                if (s_beat && (in_cmd == mmd_pkg::CMD_START)) begin
                    n_state = ST_ISSUE;
                    n_i     = '0;
                    n_k     = '0;
                end
            end
            ST_ISSUE: begin
                n_k = r_k + KW'(1);
                if (last_k) begin
                    n_state = ST_DRAIN;
                    n_drain = '0;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + DW'(1);
                if (r_drain == DW'(MAX_DIM)) begin
                    n_state = ST_EMIT;
                    n_j     = '0;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    n_j = r_j + KW'(1);
                    if (last_j) begin
                        if (last_i) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_ISSUE;
                            n_i     = r_i + KW'(1);
                            n_k     = '0;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i     <= n_i;
        r_k     <= n_k;
        r_j     <= n_j;
        r_drain <= n_drain;
    end

    // A store, one write and one registered read port
    logic [mmd_pkg::ELEM_W-1:0] r_a_mem [DEPTH];
    logic [mmd_pkg::ELEM_W-1:0] r_a_rd;
    logic [AW-1:0]              a_wr_addr;
    logic [AW-1:0]              a_rd_addr;

    assign a_wr_addr = AW'(in_row[KW-1:0]) * AW'(MAX_DIM) + AW'(in_col[KW-1:0]);
    assign a_rd_addr = AW'(r_i) * AW'(MAX_DIM) + AW'(r_k);

    always_ff @(posedge i_clk) begin
        if (s_beat && in_range && (in_cmd == mmd_pkg::CMD_LOAD_A)) begin
            r_a_mem[a_wr_addr] <= in_val;
        end
        r_a_rd <= r_a_mem[a_rd_addr];
    end

    // tags that travel with the read data into the chain
    logic                      r_iss_valid;
    logic                      r_iss_first;
    logic [mmd_pkg::IDX_W-1:0] r_iss_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
        end else begin
            r_iss_valid <= (r_state == ST_ISSUE);
        end
        r_iss_first <= (r_k == '0);
        r_iss_k     <= mmd_pkg::IDX_W'(r_k);
    end

    // B broadcast to the cells
    mmd_pkg::t_bwr bwr;

    assign bwr.en   = s_beat && in_range && (in_cmd == mmd_pkg::CMD_LOAD_B);
    assign bwr.row  = in_row;
    assign bwr.col  = in_col;
    assign bwr.data = in_val;

    // cell chain
    mmd_pkg::t_lane                    lane   [MAX_DIM + 1];
    logic signed [mmd_pkg::ACC_W-1:0]  result [MAX_DIM];

    assign lane[0].valid = r_iss_valid;
    assign lane[0].first = r_iss_first;
    assign lane[0].k     = r_iss_k;
    assign lane[0].a     = $signed(r_a_rd);

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mmd_cell #(
            .MAX_DIM (MAX_DIM),
            .COL_ID  (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_lane   (lane[g]),
            .i_bwr    (bwr),
            .o_lane   (lane[g + 1]),
            .o_result (result[g])
        );
    end

    // output register
    logic                             r_out_valid;
    logic [mmd_pkg::IDX_W-1:0]        r_out_row;
    logic [mmd_pkg::IDX_W-1:0]        r_out_col;
    logic [mmd_pkg::ACC_W-1:0]        r_out_value;
    logic                             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_row   <= mmd_pkg::IDX_W'(r_i);
            r_out_col   <= mmd_pkg::IDX_W'(r_j);
            r_out_value <= result[r_j];
            r_out_last  <= last_i && last_j;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'b0, r_out_value, r_out_col, r_out_row};

endmodule

[rtl/core/mmd_checker.sv]
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks of the dense matrix multiply block, bound to its top.
// ----------------------------------------------------------------------------
module mmd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic [mmd_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mmd_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input logic                             o_m_tlast,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready
);

    logic s_beat;

    assign s_beat = i_s_tvalid && o_s_tready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("result beat changed while stalled");

    // a start beat takes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && (i_s_tdata[1:0] == mmd_pkg::CMD_START)) |=> !o_s_tready)
        else $error("input still ready after start");

    // a load beat leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && (i_s_tdata[1:0] != mmd_pkg::CMD_START)) |=> o_s_tready)
        else $error("input not ready after load");

    // the padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:42] == 6'b0))
        else $error("nonzero padding in result beat");

endmodule

bind matrix_multiply_dense mmd_checker u_mmd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tdata  (i_s_tdata),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

[sim/matrix_multiply_dense_tb.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_dense_tb
// Self-checking bench for the dense matrix multiply block. Load and start
// beats go in on the s stream while a local product model tracks both stores
// and the size registers, queuing every C element that a start must emit.
// The monitor checks each m beat against the oldest queued element.
// ----------------------------------------------------------------------------
module matrix_multiply_dense_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM        = mmd_pkg::MAX_DIM_DEF;
    localparam int SETTLE_CYC = 40;
    localparam int HOLD_CYC   = 400;
    localparam int STALL_MAX  = 4000;
    localparam int SHOW_MAX   = 10;

    // command code the block ignores
    localparam logic [mmd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one element of the product matrix as it leaves the block
    typedef struct packed {
        logic [mmd_pkg::IDX_W-1:0] row;
        logic [mmd_pkg::IDX_W-1:0] col;
        logic [mmd_pkg::ACC_W-1:0] value;
        logic                      last;
    } t_c_elem;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic [mmd_pkg::S_TDATA_W-1:0]  i_s_tdata = '0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [mmd_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic                           o_m_tlast;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [mmd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mmd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // beats waiting to go out, and product elements still owed by the block
    logic [mmd_pkg::S_TDATA_W-1:0] pending_beats[$];
    t_c_elem                       owed_elems[$];

    // product model state
    logic [mmd_pkg::ELEM_W-1:0] a_shadow[DIM][DIM];
    logic [mmd_pkg::ELEM_W-1:0] b_shadow[DIM][DIM];
    logic [mmd_pkg::SIZE_W-1:0] rows_reg = 4'd8;
    logic [mmd_pkg::SIZE_W-1:0] cols_reg = 4'd8;
    logic [mmd_pkg::SIZE_W-1:0] inner_reg = 4'd8;

    // which entries the stimulus has loaded so far
    bit a_loaded[DIM][DIM];
    bit b_loaded[DIM][DIM];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int err_count = 0;
    int stall_cnt = 0;
    int item_cnt = 0;

    matrix_multiply_dense u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // size register as the block uses it
    function automatic int eff_size(input logic [mmd_pkg::SIZE_W-1:0] raw);
        if (raw < 1) return 1;
        if (raw > DIM) return DIM;
        return int'(raw);
    endfunction

    // apply one accepted beat to the stores, queue the product on a start
    task automatic apply_beat(input logic [mmd_pkg::S_TDATA_W-1:0] beat);
        logic [mmd_pkg::CMD_W-1:0]  cmd;
        logic [mmd_pkg::IDX_W-1:0]  row;
        logic [mmd_pkg::IDX_W-1:0]  col;
        int                         m;
        int                         n;
        int                         kk;
        longint                     acc;
        t_c_elem                    elem;
        cmd = beat[1:0];
        row = beat[4:2];
        col = beat[7:5];
        m   = eff_size(rows_reg);
        n   = eff_size(cols_reg);
        kk  = eff_size(inner_reg);
        case (cmd)
            mmd_pkg::CMD_LOAD_A: a_shadow[row][col] = beat[23:8];
            mmd_pkg::CMD_LOAD_B: b_shadow[row][col] = beat[23:8];
            mmd_pkg::CMD_START: begin
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = 0;
                        for (int k = 0; k < kk; k++)
                            acc += longint'($signed(a_shadow[i][k])) *
                                   longint'($signed(b_shadow[k][j]));
                        elem.row   = mmd_pkg::IDX_W'(i);
                        elem.col   = mmd_pkg::IDX_W'(j);
                        elem.value = acc[mmd_pkg::ACC_W-1:0];
                        elem.last  = (i == m - 1) && (j == n - 1);
                        owed_elems.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // source side: present queued beats, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                apply_beat(i_s_tdata);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tdata  <= pending_beats.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: random back-pressure plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_taken != hold_asks) begin
            hold_taken = hold_taken + 1;
            hold_left  = HOLD_CYC;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input t_c_elem want,
                                   input t_c_elem got);
        err_count++;
        if (err_count <= SHOW_MAX) begin
            $display("%0t mismatch (%s): exp row %0d col %0d value %h last %b",
                     $realtime, what, want.row, want.col, want.value, want.last);
            $display("%0t mismatch (%s): got row %0d col %0d value %h last %b",
                     $realtime, what, got.row, got.col, got.value, got.last);
        end
    endtask

    // monitor: check every result beat against the oldest owed element
    always @(posedge i_clk) begin
        t_c_elem got;
        t_c_elem want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.row   = o_m_tdata[2:0];
            got.col   = o_m_tdata[5:3];
            got.value = o_m_tdata[41:6];
            got.last  = o_m_tlast;
            if (owed_elems.size() == 0) begin
                report_mismatch("unexpected beat", '0, got);
            end else begin
                want = owed_elems.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.value !== want.value || got.last !== want.last)
                    report_mismatch("field", want, got);
            end
        end
    end

    // watchdog on cycles with no beat on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_MAX) begin
            $display("FAIL matrix_multiply_dense");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [mmd_pkg::S_TDATA_W-1:0] pack_beat(
        input logic [mmd_pkg::CMD_W-1:0]  cmd,
        input logic [mmd_pkg::IDX_W-1:0]  row,
        input logic [mmd_pkg::IDX_W-1:0]  col,
        input logic [mmd_pkg::ELEM_W-1:0] val);
        return {val, col, row, cmd};
    endfunction

    function automatic logic [mmd_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 19))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return mmd_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    task automatic queue_load(input logic [mmd_pkg::CMD_W-1:0] cmd, input int row,
                              input int col, input logic [mmd_pkg::ELEM_W-1:0] val);
        pending_beats.push_back(pack_beat(cmd, mmd_pkg::IDX_W'(row), mmd_pkg::IDX_W'(col),
                                          val));
        if (cmd == mmd_pkg::CMD_LOAD_A) a_loaded[row][col] = 1'b1;
        if (cmd == mmd_pkg::CMD_LOAD_B) b_loaded[row][col] = 1'b1;
        item_cnt++;
    endtask

    // start beat, first loading whatever entries the product would read unset
    task automatic queue_start();
        int m;
        int n;
        int kk;
        m  = eff_size(rows_reg);
        n  = eff_size(cols_reg);
        kk = eff_size(inner_reg);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < kk; k++)
                if (!a_loaded[i][k]) queue_load(mmd_pkg::CMD_LOAD_A, i, k, rand_elem());
        for (int k = 0; k < kk; k++)
            for (int j = 0; j < n; j++)
                if (!b_loaded[k][j]) queue_load(mmd_pkg::CMD_LOAD_B, k, j, rand_elem());
        pending_beats.push_back(pack_beat(mmd_pkg::CMD_START, mmd_pkg::IDX_W'($urandom),
                                          mmd_pkg::IDX_W'($urandom),
                                          mmd_pkg::ELEM_W'($urandom)));
        item_cnt++;
    endtask

    // let the block drain completely, loads included
    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_s_tvalid || owed_elems.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmd_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            mmd_pkg::REG_ROWS:  rows_reg = data;
            mmd_pkg::REG_COLS:  cols_reg = data;
            mmd_pkg::REG_INNER: inner_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_sizes(input logic [mmd_pkg::SIZE_W-1:0] rows,
                             input logic [mmd_pkg::SIZE_W-1:0] cols,
                             input logic [mmd_pkg::SIZE_W-1:0] inner);
        wait_idle();
        write_reg(mmd_pkg::REG_ROWS, rows);
        write_reg(mmd_pkg::REG_COLS, cols);
        write_reg(mmd_pkg::REG_INNER, inner);
    endtask

    // mostly load runs closed by a start, some noise on top
    task automatic random_burst(input int n_items);
        int target;
        int sel;
        int m;
        int n;
        int kk;
        int row;
        int col;
        logic [mmd_pkg::CMD_W-1:0] cmd;
        target = item_cnt + n_items;
        m  = eff_size(rows_reg);
        n  = eff_size(cols_reg);
        kk = eff_size(inner_reg);
        while (item_cnt < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // unused command, ignored by the block
                pending_beats.push_back(pack_beat(CMD_UNUSED, mmd_pkg::IDX_W'($urandom),
                                                  mmd_pkg::IDX_W'($urandom),
                                                  mmd_pkg::ELEM_W'($urandom)));
                item_cnt++;
            end else if (sel < 78) begin
                cmd = $urandom_range(0, 1) ? mmd_pkg::CMD_LOAD_B : mmd_pkg::CMD_LOAD_A;
                if ($urandom_range(0, 4) == 0) begin
                    row = $urandom_range(0, DIM - 1);
                    col = $urandom_range(0, DIM - 1);
                end else if (cmd == mmd_pkg::CMD_LOAD_A) begin
                    row = $urandom_range(0, m - 1);
                    col = $urandom_range(0, kk - 1);
                end else begin
                    row = $urandom_range(0, kk - 1);
                    col = $urandom_range(0, n - 1);
                end
                queue_load(cmd, row, col, rand_elem());
            end else begin
                queue_start();
            end
        end
        queue_start();
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 60;

        // directed: extreme values and indexes, ignored fields, unused command
        set_sizes(4'd2, 4'd2, 4'd2);
        queue_load(mmd_pkg::CMD_LOAD_A, 0, 0, 16'h7FFF);
        queue_load(mmd_pkg::CMD_LOAD_A, 0, 1, 16'h8000);
        queue_load(mmd_pkg::CMD_LOAD_A, 1, 0, 16'h8000);
        queue_load(mmd_pkg::CMD_LOAD_A, 1, 1, 16'h0001);
        queue_load(mmd_pkg::CMD_LOAD_B, 0, 0, 16'h7FFF);
        queue_load(mmd_pkg::CMD_LOAD_B, 0, 1, 16'h8000);
        queue_load(mmd_pkg::CMD_LOAD_B, 1, 0, 16'h8000);
        queue_load(mmd_pkg::CMD_LOAD_B, 1, 1, 16'hFFFF);
        queue_load(mmd_pkg::CMD_LOAD_A, 7, 7, 16'h8000);
        queue_load(mmd_pkg::CMD_LOAD_B, 7, 0, 16'h0000);
        queue_load(mmd_pkg::CMD_LOAD_B, 0, 7, 16'h7FFF);
        pending_beats.push_back({mmd_pkg::S_TDATA_W{1'b1}});
        item_cnt++;
        pending_beats.push_back(pack_beat(mmd_pkg::CMD_START, 3'd7, 3'd7, 16'hFFFF));
        item_cnt++;
        queue_start();

        // size registers at zero act as one
        set_sizes(4'd0, 4'd0, 4'd0);
        queue_start();

        // sender idles less than receiver
        set_sizes(4'd15, 4'd9, 4'd12);
        random_burst(38);
        set_sizes(4'd1, 4'd8, 4'd3);
        random_burst(38);

        // roles swapped; long sink hold-off with the source still pushing
        send_idle_pct = 60;
        recv_idle_pct = 29;
        set_sizes(4'd8, 4'd8, 4'd8);
        hold_asks++;
        queue_start();
        random_burst(38);
        set_sizes(4'd3, 4'd1, 4'd5);
        random_burst(38);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sizes(mmd_pkg::SIZE_W'($urandom_range(1, 8)),
                  mmd_pkg::SIZE_W'($urandom_range(1, 8)),
                  mmd_pkg::SIZE_W'($urandom_range(1, 8)));
        random_burst(38);
        set_sizes(4'd8, 4'd1, 4'd1);
        random_burst(38);

        wait_idle();
        if (err_count == 0 && owed_elems.size() == 0) begin
            $display("PASS matrix_multiply_dense");
        end else begin
            $display("FAIL matrix_multiply_dense");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/mmd_pkg.sv
rtl/core/mmd_cell.sv
rtl/core/matrix_multiply_dense.sv
rtl/core/mmd_checker.sv
sim/matrix_multiply_dense_tb.sv
